// ===== src/chat_pkg.sv =====
// Shared types and constants for the clock hand angle tracker.
`default_nettype none
package chat_pkg;

	// Configuration register indexes
	localparam int unsigned CfgIndexW = 1;
	localparam logic [CfgIndexW-1:0] RegHourPeriod   = 1'b0;
	localparam logic [CfgIndexW-1:0] RegMinutePeriod = 1'b1;

	localparam int unsigned PeriodW = 31;
	localparam int unsigned StampW  = 32;
	localparam int unsigned AngleW  = 32;

	localparam logic [PeriodW-1:0] HourPeriodReset   = 31'd3600000;
	localparam logic [PeriodW-1:0] MinutePeriodReset = 31'd60000;

	// Divider geometry: left-aligned 64-bit dividend, one quotient bit per cycle
	localparam int unsigned DvdW    = 64;
	localparam int unsigned StepCntW = 6;
	localparam logic [StepCntW-1:0] DeltaSteps = 6'd32;
	localparam logic [StepCntW-1:0] ModSteps   = 6'd31;
	localparam logic [StepCntW-1:0] QuoSteps   = 6'd62;

	// Microprogram addresses
	typedef logic [3:0] step_t;
	localparam step_t StIdle      = 4'd0;
	localparam step_t StCheck     = 4'd1;
	localparam step_t StDeltaGo   = 4'd2;
	localparam step_t StDeltaWait = 4'd3;
	localparam step_t StSum       = 4'd4;
	localparam step_t StWrap      = 4'd5;
	localparam step_t StMinModGo  = 4'd6;
	localparam step_t StMinModWt  = 4'd7;
	localparam step_t StMinQGo    = 4'd8;
	localparam step_t StMinQWait  = 4'd9;
	localparam step_t StHourQGo   = 4'd10;
	localparam step_t StHourQWait = 4'd11;
	localparam step_t StHourWb    = 4'd12;
	localparam step_t StFirst     = 4'd13;
	localparam step_t StEmit      = 4'd14;
	localparam step_t StReturn    = 4'd15;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_NOT_STARTED,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DELTA_MOD,
		OP_MIN_MOD,
		OP_MIN_Q,
		OP_HOUR_Q
	} div_op_t;

	typedef enum logic [2:0] {
		A_NONE,
		A_TAKE,
		A_LAST,
		A_SUM,
		A_WRAP,
		A_MINUTE,
		A_HOUR,
		A_EMIT
	} act_t;

	typedef struct packed {
		cond_t   cond;
		step_t   target;
		div_op_t div_op;
		act_t    act;
	} cw_t;

	typedef struct packed {
		logic no_input;
		logic not_started;
		logic div_busy;
		logic out_full;
	} flags_t;

endpackage
`default_nettype wire

// ===== src/chat_if.sv =====
// Stream interfaces for timestamp beats in and angle beats out.
`default_nettype none
interface chat_ts_if;
	logic        valid;
	logic        ready;
	logic [31:0] timestamp_ms;

	modport source (output valid, output timestamp_ms, input ready);
	modport sink (input valid, input timestamp_ms, output ready);
endinterface

interface chat_angle_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] hour_angle;
	logic signed [31:0] minute_angle;
	logic               primed;

	modport source (output valid, output hour_angle, output minute_angle, output primed,
		input ready);
	modport sink (input valid, input hour_angle, input minute_angle, input primed,
		output ready);
endinterface
`default_nettype wire

// ===== src/chat_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module chat_divider (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [chat_pkg::DvdW-1:0]     dividend,
	input  wire logic [chat_pkg::PeriodW-1:0]  divisor,
	input  wire logic [chat_pkg::StepCntW-1:0] steps,
	output      logic                          busy,
	output      logic [chat_pkg::AngleW-1:0]   quo,
	output      logic [chat_pkg::PeriodW-1:0]  rem
);
	import chat_pkg::*;

	logic [StepCntW-1:0] cnt_q;
	logic [DvdW-1:0]     dvd_q;
	logic [PeriodW-1:0]  div_q;
	logic [PeriodW-1:0]  rem_q;
	logic [AngleW-1:0]   quo_q;

	logic [PeriodW:0]    shifted;
	logic [PeriodW+1:0]  diff;
	logic                ge;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		shifted = {rem_q, dvd_q[DvdW-1]};
		diff    = {1'b0, shifted} - {2'b00, div_q};
		ge      = ~diff[PeriodW+1];
	end

	// Count down the remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= steps;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Load operands, then shift one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
			rem_q <= ge ? diff[PeriodW-1:0] : shifted[PeriodW-1:0];
			quo_q <= {quo_q[AngleW-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== src/chat_sequencer.sv =====
// Step counter and control store for the angle tracker microprogram.
`default_nettype none
module chat_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire chat_pkg::flags_t flags,
	output      chat_pkg::cw_t    cw
);
	import chat_pkg::*;

	step_t step_q;
	logic  take;

	// Control store: one word per step
	function automatic cw_t rom(input step_t s);
		cw_t w;
		w = '{cond: C_NEXT, target: StIdle, div_op: OP_NONE, act: A_NONE};
		unique case (s)
			StIdle:      w = '{C_NO_INPUT,    StIdle,      OP_NONE,      A_TAKE};
			StCheck:     w = '{C_NOT_STARTED, StFirst,     OP_NONE,      A_NONE};
			StDeltaGo:   w = '{C_NEXT,        StIdle,      OP_DELTA_MOD, A_LAST};
			StDeltaWait: w = '{C_DIV_BUSY,    StDeltaWait, OP_NONE,      A_NONE};
			StSum:       w = '{C_NEXT,        StIdle,      OP_NONE,      A_SUM};
			StWrap:      w = '{C_NEXT,        StIdle,      OP_NONE,      A_WRAP};
			StMinModGo:  w = '{C_NEXT,        StIdle,      OP_MIN_MOD,   A_NONE};
			StMinModWt:  w = '{C_DIV_BUSY,    StMinModWt,  OP_NONE,      A_NONE};
			StMinQGo:    w = '{C_NEXT,        StIdle,      OP_MIN_Q,     A_NONE};
			StMinQWait:  w = '{C_DIV_BUSY,    StMinQWait,  OP_NONE,      A_NONE};
			StHourQGo:   w = '{C_NEXT,        StIdle,      OP_HOUR_Q,    A_MINUTE};
			StHourQWait: w = '{C_DIV_BUSY,    StHourQWait, OP_NONE,      A_NONE};
			StHourWb:    w = '{C_ALWAYS,      StEmit,      OP_NONE,      A_HOUR};
			StFirst:     w = '{C_NEXT,        StIdle,      OP_NONE,      A_LAST};
			StEmit:      w = '{C_OUT_FULL,    StEmit,      OP_NONE,      A_EMIT};
			StReturn:    w = '{C_ALWAYS,      StIdle,      OP_NONE,      A_NONE};
			default:     w = '{C_ALWAYS,      StIdle,      OP_NONE,      A_NONE};
		endcase
		return w;
	endfunction

	assign cw = rom(step_q);

	// Evaluate the jump condition
	always_comb begin
		unique case (cw.cond)
			C_NEXT:        take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_NO_INPUT:    take = flags.no_input;
			C_NOT_STARTED: take = flags.not_started;
			C_DIV_BUSY:    take = flags.div_busy;
			C_OUT_FULL:    take = flags.out_full;
			default:       take = 1'b0;
		endcase
	end

	// Advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StIdle;
		end else begin
			step_q <= take ? cw.target : step_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== src/clock_hand_angle_tracker.sv =====
// Top level: clock hand angle tracker datapath around a microcoded sequencer.
//
//  channel  | dir | beat payload                          | handshake
//  ---------+-----+---------------------------------------+--------------
//  stamp    | in  | timestamp_ms[31:0]                    | valid/ready
//  angles   | out | hour_angle, minute_angle, primed      | valid/ready
//  cfg      | in  | cfg_index, cfg_data[30:0]             | cfg_we only
//
// The first beat after reset uses no divider: it records its stamp and emits.
// Every later beat runs four divisions on the single shared divider at one bit
// per cycle: delta mod hour period, elapsed mod minute period, two quotients.
// One beat is worked on at a time; a new stamp is taken while the previous
// result still waits in the output register, and a result that cannot leave
// holds the sequencer at its emit step. Reset is asynchronous; it clears the
// tracker state, sets periods to defaults; stamp, sum, payload are not reset.
`default_nettype none
module clock_hand_angle_tracker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [chat_pkg::CfgIndexW-1:0]  cfg_index,
	input  wire logic [chat_pkg::PeriodW-1:0]    cfg_data,
	chat_ts_if.sink                              stamp,
	chat_angle_if.source                         angles
);
	import chat_pkg::*;

	// Configuration and tracker state
	logic [PeriodW-1:0] hp_cfg_q;
	logic [PeriodW-1:0] mp_cfg_q;
	logic [StampW-1:0]  ts_q;
	logic [StampW-1:0]  last_q;
	logic [PeriodW-1:0] elapsed_q;
	logic [PeriodW:0]   sum_q;
	logic [AngleW-1:0]  hour_q;
	logic [AngleW-1:0]  minute_q;
	logic               started_q;

	// Output register
	logic               out_valid_q;
	logic [AngleW-1:0]  out_hour_q;
	logic [AngleW-1:0]  out_minute_q;
	logic               out_primed_q;

	logic [PeriodW-1:0] hp;
	logic [PeriodW-1:0] mp;
	logic               out_full;
	logic               in_take;

	cw_t                cw;
	flags_t             flags;

	logic                div_start;
	logic [DvdW-1:0]     div_dividend;
	logic [PeriodW-1:0]  div_divisor;
	logic [StepCntW-1:0] div_steps;
	logic                div_busy;
	logic [AngleW-1:0]   div_quo;
	logic [PeriodW-1:0]  div_rem;

	// A zero period behaves as one
	assign hp = (hp_cfg_q == '0) ? PeriodW'(1) : hp_cfg_q;
	assign mp = (mp_cfg_q == '0) ? PeriodW'(1) : mp_cfg_q;

	assign out_full = out_valid_q & ~angles.ready;
	assign in_take  = (cw.act == A_TAKE);

	assign stamp.ready         = in_take;
	assign angles.valid        = out_valid_q;
	assign angles.hour_angle   = out_hour_q;
	assign angles.minute_angle = out_minute_q;
	assign angles.primed       = out_primed_q;

	// Condition flags for the sequencer
	always_comb begin
		flags.no_input    = ~stamp.valid;
		flags.not_started = ~started_q;
		flags.div_busy    = div_busy;
		flags.out_full    = out_full;
	end

	chat_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	// Pick divider operands; phases are left-aligned, Q31 shifts add steps
	always_comb begin
		div_start    = (cw.div_op != OP_NONE);
		div_dividend = '0;
		div_divisor  = hp;
		div_steps    = '0;
		unique case (cw.div_op)
			OP_NONE: begin
				div_dividend = '0;
			end
			OP_DELTA_MOD: begin
				div_dividend = {ts_q - last_q, {(DvdW-StampW){1'b0}}};
				div_divisor  = hp;
				div_steps    = DeltaSteps;
			end
			OP_MIN_MOD: begin
				div_dividend = {elapsed_q, {(DvdW-PeriodW){1'b0}}};
				div_divisor  = mp;
				div_steps    = ModSteps;
			end
			OP_MIN_Q: begin
				div_dividend = {div_rem, {(DvdW-PeriodW){1'b0}}};
				div_divisor  = mp;
				div_steps    = QuoSteps;
			end
			OP_HOUR_Q: begin
				div_dividend = {elapsed_q, {(DvdW-PeriodW){1'b0}}};
				div_divisor  = hp;
				div_steps    = QuoSteps;
			end
			default: begin
				div_dividend = '0;
			end
		endcase
	end

	chat_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Period registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_cfg_q <= HourPeriodReset;
			mp_cfg_q <= MinutePeriodReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				RegHourPeriod:   hp_cfg_q <= cfg_data;
				RegMinutePeriod: mp_cfg_q <= cfg_data;
				default:         hp_cfg_q <= hp_cfg_q;
			endcase
		end
	end

	// Execute the datapath action of the current step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q       <= '0;
			elapsed_q    <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			started_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the output beat once taken
			if (out_valid_q && angles.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cw.act)
				A_NONE, A_TAKE, A_SUM: begin
				end
				A_LAST: begin
					last_q <= ts_q;
				end
				A_WRAP: begin
					elapsed_q <= (sum_q >= {1'b0, hp}) ? PeriodW'(sum_q - {1'b0, hp})
						: sum_q[PeriodW-1:0];
				end
				A_MINUTE: begin
					minute_q <= '0 - div_quo;
				end
				A_HOUR: begin
					hour_q <= '0 - div_quo;
				end
				A_EMIT: begin
					if (!out_full) begin
						out_valid_q <= 1'b1;
						started_q   <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: stamp capture, running sum, output beat
	always_ff @(posedge clk) begin
		if (stamp.valid && in_take) begin
			ts_q <= stamp.timestamp_ms;
		end
		if (cw.act == A_SUM) begin
			sum_q <= {1'b0, elapsed_q} + {1'b0, div_rem};
		end
		if (cw.act == A_EMIT && !out_full) begin
			out_hour_q   <= hour_q;
			out_minute_q <= minute_q;
			out_primed_q <= started_q;
		end
	end

endmodule
`default_nettype wire

// ===== test/clock_hand_angle_tracker_tb.sv =====
// Self-checking testbench for the clock hand angle tracker: random stamps, periods and stalls.
module clock_hand_angle_tracker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import chat_pkg::*;

	localparam int unsigned CycleLimit = 1_000_000;
	localparam int unsigned LongHold   = 3000;

	typedef struct {
		logic signed [AngleW-1:0] hour_angle;
		logic signed [AngleW-1:0] minute_angle;
		logic                     primed;
	} angle_beat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [PeriodW-1:0]   cfg_data;

	chat_ts_if    stamp ();
	chat_angle_if angles ();

	clock_hand_angle_tracker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.stamp    (stamp),
		.angles   (angles)
	);

	// Stamps waiting to be offered and angle beats still owed by the block
	logic [StampW-1:0] stamp_queue[$];
	angle_beat_t       angle_expect[$];
	logic [StampW-1:0] stamp_cursor = '0;

	// Predicted clock state and the period settings it runs under
	logic [PeriodW-1:0]       hour_per   = HourPeriodReset;
	logic [PeriodW-1:0]       min_per    = MinutePeriodReset;
	logic [StampW-1:0]        last_ts    = '0;
	logic [PeriodW-1:0]       elapsed_ms = '0;
	logic signed [AngleW-1:0] hour_ang   = '0;
	logic signed [AngleW-1:0] min_ang    = '0;
	logic                     running    = 1'b0;

	int unsigned mismatches = 0;
	int unsigned beats_seen = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;
	int unsigned send_gap = 0;
	int unsigned send_quiet = 0;
	int unsigned take_stall = 0;
	int unsigned take_quiet = 0;
	int unsigned hold_left = 0;

	always #4 clk = ~clk;

	// Negated Q31 fraction of a turn, cut to 32 bits
	function automatic logic [AngleW-1:0] turn_fraction(input logic [31:0] phase,
			input logic [31:0] period);
		logic [63:0] q;
		q = {1'b0, phase, 31'b0} / {32'b0, period};
		return 32'd0 - q[31:0];
	endfunction

	// Advance the predicted clock by one stamp and return the beat it yields
	function automatic angle_beat_t advance_clock(input logic [StampW-1:0] ts);
		angle_beat_t beat;
		logic [31:0] hp;
		logic [31:0] mp;
		logic [31:0] delta;
		logic [31:0] sum;
		hp = (hour_per == '0) ? 32'd1 : {1'b0, hour_per};
		mp = (min_per == '0) ? 32'd1 : {1'b0, min_per};
		beat.primed = running;
		if (!running) begin
			last_ts = ts;
			running = 1'b1;
		end else begin
			delta = (ts - last_ts) % hp;
			last_ts = ts;
			sum = {1'b0, elapsed_ms} + delta;
			if (sum >= hp)
				sum = sum - hp;
			elapsed_ms = sum[PeriodW-1:0];
			min_ang = turn_fraction({1'b0, elapsed_ms} % mp, mp);
			hour_ang = turn_fraction({1'b0, elapsed_ms}, hp);
		end
		beat.hour_angle = hour_ang;
		beat.minute_angle = min_ang;
		return beat;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d (0x%08h) got %0d (0x%08h)", $time, name,
				$signed(want), want, $signed(got), got);
			mismatches++;
		end
	endfunction

	// Mostly forward steps of up to 2000 ms, some long gaps, jumps and steps back
	function automatic logic [StampW-1:0] next_stamp();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			stamp_cursor += $urandom_range(0, 2000);
		else if (pick < 80)
			stamp_cursor += $urandom_range(0, 20_000_000);
		else if (pick < 92)
			stamp_cursor = $urandom();
		else
			stamp_cursor -= $urandom_range(0, 5000);
		return stamp_cursor;
	endfunction

	task automatic offer(input logic [StampW-1:0] ts);
		stamp_queue.push_back(ts);
		stamp_cursor = ts;
	endtask

	// Wait until every stamp is taken and every beat has come back, then let the block settle
	task automatic settle(input int unsigned cycles);
		do
			@(negedge clk);
		while (stamp_queue.size() != 0 || stamp.valid || angle_expect.size() != 0);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_periods(input logic [PeriodW-1:0] hour,
			input logic [PeriodW-1:0] minute);
		settle(16);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= RegHourPeriod;
		cfg_data <= hour;
		@(posedge clk);
		cfg_index <= RegMinutePeriod;
		cfg_data <= minute;
		@(posedge clk);
		cfg_we <= 1'b0;
		hour_per = hour;
		min_per = minute;
	endtask

	task automatic random_run(input logic [PeriodW-1:0] hour, input logic [PeriodW-1:0] minute,
			input int unsigned n);
		write_periods(hour, minute);
		repeat (n) offer(next_stamp());
	endtask

	// Send side: hold a beat until taken, otherwise idle in bursts or offer the next stamp
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp.valid <= 1'b0;
			stamp.timestamp_ms <= '0;
			send_gap = 0;
		end else begin
			if (stamp.valid && stamp.ready)
				angle_expect.push_back(advance_clock(stamp.timestamp_ms));
			if (send_quiet != 0)
				send_quiet--;
			else if ($urandom_range(0, 999) == 0)
				send_quiet = $urandom_range(200, 2000);
			if (stamp.valid && !stamp.ready) begin
				// hold the beat on offer
			end else if (send_gap != 0) begin
				send_gap--;
				stamp.valid <= 1'b0;
			end else if (!calm && send_quiet == 0 && $urandom_range(0, 99) < 10) begin
				send_gap = $urandom_range(1, 17) - 1;
				stamp.valid <= 1'b0;
			end else if (stamp_queue.size() != 0) begin
				stamp.valid <= 1'b1;
				stamp.timestamp_ms <= stamp_queue.pop_front();
			end else begin
				stamp.valid <= 1'b0;
			end
		end
	end

	// Receive side: check each angle beat, stall in bursts and twice for a long stretch
	always @(posedge clk or negedge arst_n) begin
		angle_beat_t want;
		if (!arst_n) begin
			angles.ready <= 1'b0;
			take_stall = 0;
			hold_left = 0;
		end else begin
			if (angles.valid && angles.ready) begin
				beats_seen++;
				if (beats_seen == 200 || beats_seen == 400)
					hold_left = LongHold;
				if (angle_expect.size() == 0) begin
					$display("%0t: unexpected beat hour_angle %0d minute_angle %0d primed %0b",
						$time, angles.hour_angle, angles.minute_angle, angles.primed);
					mismatches++;
				end else begin
					want = angle_expect.pop_front();
					check_field("hour_angle", want.hour_angle, angles.hour_angle);
					check_field("minute_angle", want.minute_angle, angles.minute_angle);
					check_field("primed", {31'b0, want.primed}, {31'b0, angles.primed});
				end
			end
			if (take_quiet != 0)
				take_quiet--;
			else if ($urandom_range(0, 999) == 0)
				take_quiet = $urandom_range(200, 2000);
			if (hold_left != 0) begin
				hold_left--;
				angles.ready <= 1'b0;
			end else if (take_stall != 0) begin
				take_stall--;
				angles.ready <= 1'b0;
			end else if (!calm && take_quiet == 0 && $urandom_range(0, 99) < 10) begin
				take_stall = $urandom_range(1, 17) - 1;
				angles.ready <= 1'b0;
			end else begin
				angles.ready <= 1'b1;
			end
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("%0t: timeout, %0d beats still owed", $time, angle_expect.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [31:0] gap;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = RegHourPeriod;
		cfg_data = '0;
		stamp.valid = 1'b0;
		stamp.timestamp_ms = '0;
		angles.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Default periods: first stamp, zero step, full-range wrap, whole and half hours
		offer(32'h0000_0000);
		offer(32'h0000_0000);
		offer(32'hFFFF_FFFF);
		offer(32'h0000_0000);
		offer(32'd3_600_000);
		offer(32'd5_400_000);
		offer(32'h7FFF_FFFF);
		offer(32'h8000_0000);
		offer(32'h5555_5555);
		offer(32'hAAAA_AAAA);

		// Zero periods behave as one
		write_periods('0, '0);
		offer(stamp_cursor + 32'd5);
		offer(stamp_cursor + 32'd123_456);
		offer(32'hFFFF_FFFF);

		// Widest periods, then drive elapsed close to the top
		write_periods(31'h7FFF_FFFF, 31'h7FFF_FFFF);
		offer(stamp_cursor + 32'h7FFF_FFFE);
		offer(stamp_cursor + 32'd1);
		settle(0);
		if (elapsed_ms <= 31'h7FFF_FF00)
			gap = 32'h7FFF_FF00 - {1'b0, elapsed_ms};
		else
			gap = 32'h7FFF_FFFF - {1'b0, elapsed_ms} + 32'h7FFF_FF00;
		offer(stamp_cursor + gap);

		// Hour period dropped far below elapsed: one subtraction leaves it out of range
		write_periods(31'd1000, 31'd7);
		offer(stamp_cursor);
		offer(stamp_cursor + 32'd999);
		offer(stamp_cursor + 32'd3);

		// Random stamps under a spread of periods
		random_run(HourPeriodReset, MinutePeriodReset, 70);
		random_run(31'd1, 31'd1, 70);
		random_run(31'h7FFF_FFFF, 31'd1, 70);
		random_run(31'd1000, 31'h7FFF_FFFF, 70);
		random_run(PeriodW'($urandom_range(32'h7FFF_FFFF, 32'h1000_0000)),
			PeriodW'($urandom_range(1, 100_000)), 70);
		random_run(PeriodW'($urandom_range(2, 5000)), PeriodW'($urandom_range(1, 500)), 70);
		random_run('0, PeriodW'($urandom_range(1, 32'h7FFF_FFFF)), 60);
		random_run(31'h7FFF_FFFF, 31'h7FFF_FFFE, 60);
		random_run(PeriodW'($urandom_range(1, 300)), '0, 60);

		// Last stretch with both sides always ready
		settle(16);
		calm = 1'b1;
		random_run(HourPeriodReset, MinutePeriodReset, 70);

		settle(250);
		if (mismatches == 0 && angle_expect.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
